// ----- design/lob_pkg.sv -----
// ----------------------------------------------------------------------------
// lob_pkg
// Shared constants for the order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int ORDER_SLOTS_DEF = 64;
  localparam int PRICE_BITS_DEF  = 16;
  localparam int ID_BITS_DEF     = 32;
  localparam int QTY_BITS        = 32;
  localparam int ARR_BITS        = 32;
  localparam int STATUS_BITS     = 3;
  localparam int MAX_FILLS       = 63;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DUP     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_ZERO    = 3'd4;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BID   = 1'b0;
  localparam logic SIDE_ASK   = 1'b1;
  localparam logic KIND_FILL  = 1'b0;
  localparam logic KIND_STAT  = 1'b1;

endpackage

// ----- design/lob_front.sv -----
// ----------------------------------------------------------------------------
// lob_front
// Request intake: register items and queue them for the matching engine.
// ----------------------------------------------------------------------------
module lob_front #(
  parameter int W     = 82,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         q_valid,
  input  logic         q_ready,
  output logic [W-1:0] q_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic push, pop;

  assign in_ready = (count != (AW+1)'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_data   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == (AW+1)'(DEPTH)) |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count step");
endmodule

// ----- design/lob_engine.sv -----
// ----------------------------------------------------------------------------
// lob_engine
// Matching engine: slot scans over cycles, fill and status emission.
// ----------------------------------------------------------------------------
module lob_engine #(
  parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_BITS  = lob_pkg::PRICE_BITS_DEF,
  parameter int ID_BITS     = lob_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic                         q_cmd,
  input  logic [ID_BITS-1:0]           q_id,
  input  logic                         q_side,
  input  logic [PRICE_BITS-1:0]        q_price,
  input  logic [lob_pkg::QTY_BITS-1:0] q_qty,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         o_kind,
  output logic [lob_pkg::STATUS_BITS-1:0] o_status,
  output logic [PRICE_BITS-1:0]        o_fill_price,
  output logic [lob_pkg::QTY_BITS-1:0] o_fill_qty,
  output logic [ID_BITS-1:0]           o_buy_id,
  output logic [ID_BITS-1:0]           o_sell_id,
  output logic [PRICE_BITS-1:0]        o_best_bid,
  output logic                         o_bid_present,
  output logic [PRICE_BITS-1:0]        o_best_ask,
  output logic                         o_ask_present,
  output logic                         o_last
);
  localparam int SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int QB = lob_pkg::QTY_BITS;
  localparam int AB = lob_pkg::ARR_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAN1 = 8'b00000010,
    S_DEC   = 8'b00000100,
    S_SCAN2 = 8'b00001000,
    S_MATCH = 8'b00010000,
    S_UPDB  = 8'b00100000,
    S_UPDA  = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_t;

  typedef struct packed {
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QB-1:0]         rem;
    logic [ID_BITS-1:0]    id;
    logic [AB-1:0]         arr;
  } slot_t;

  state_t state;
  logic [ORDER_SLOTS-1:0] used;
  slot_t                  slot_m [ORDER_SLOTS];
  slot_t                  rd_data;
  logic [SW-1:0]          rd_addr;
  logic                   wr_en;
  logic [SW-1:0]          wr_addr;
  slot_t                  wr_data;
  logic [AB-1:0]          arr_cnt;

  // request copy
  logic                  r_cmd, r_side;
  logic [ID_BITS-1:0]    r_id;
  logic [PRICE_BITS-1:0] r_price;
  logic [QB-1:0]         r_qty;
  logic [lob_pkg::STATUS_BITS-1:0] r_status;
  logic [5:0]            nfill;
  logic                  final_pass;
  logic                  add_ok;

  // scan state
  logic [SW:0]   idx;
  logic          found_v, free_v;
  logic [SW-1:0] found_i, free_i;
  logic          b_v, a_v;
  logic [SW-1:0] b_i, a_i;
  slot_t         b_ent, a_ent;
  logic [AB-1:0] b_age, a_age;
  logic [QB-1:0] m_qty;

  // scan element: the slot read in the cycle before
  logic [SW-1:0] si, pi;
  logic          last_idx, proc;
  logic [AB-1:0] s_age;
  logic          s_used;
  logic          bid_better, ask_better;
  logic          out_load;

  assign si       = idx[SW-1:0];
  assign pi       = si - 1'b1;
  assign last_idx = (idx == (SW+1)'(ORDER_SLOTS));
  assign proc     = (idx != '0);
  assign rd_addr  = last_idx ? '0 : si;
  assign s_used   = used[pi];
  assign s_age    = arr_cnt - rd_data.arr;
  assign add_ok   = (r_cmd == lob_pkg::CMD_ADD) && (r_qty != '0) && !found_v && free_v;
  assign q_ready  = (state == S_IDLE);
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    bid_better = 1'b0;
    ask_better = 1'b0;
    if (proc && s_used && rd_data.side == lob_pkg::SIDE_BID) begin
      bid_better = !b_v || (rd_data.price > b_ent.price) ||
                   (rd_data.price == b_ent.price && s_age > b_age);
    end
    if (proc && s_used && rd_data.side == lob_pkg::SIDE_ASK) begin
      ask_better = !a_v || (rd_data.price < a_ent.price) ||
                   (rd_data.price == a_ent.price && s_age > a_age);
    end
  end

  // one write a cycle: new order on add, updated remainder after a fill
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = free_i;
    wr_data.side  = r_side;
    wr_data.price = r_price;
    wr_data.rem   = r_qty;
    wr_data.id    = r_id;
    wr_data.arr   = arr_cnt;
    case (state)
      S_DEC: begin
        wr_en = add_ok;
      end
      S_UPDB: begin
        wr_en       = 1'b1;
        wr_addr     = b_i;
        wr_data     = b_ent;
        wr_data.rem = b_ent.rem - m_qty;
      end
      S_UPDA: begin
        wr_en       = 1'b1;
        wr_addr     = a_i;
        wr_data     = a_ent;
        wr_data.rem = a_ent.rem - m_qty;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_m[wr_addr] <= wr_data;
    end
    rd_data <= slot_m[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      arr_cnt <= '0;
      idx     <= '0;
      nfill   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            r_cmd   <= q_cmd;
            r_id    <= q_id;
            r_side  <= q_side;
            r_price <= q_price;
            r_qty   <= q_qty;
            idx     <= '0;
            found_v <= 1'b0;
            free_v  <= 1'b0;
            state   <= S_SCAN1;
          end
        end
        // look up the id and the lowest free slot
        S_SCAN1: begin
          if (proc) begin
            if (s_used && rd_data.id == r_id && !found_v) begin
              found_v <= 1'b1;
              found_i <= pi;
            end
            if (!s_used && !free_v) begin
              free_v <= 1'b1;
              free_i <= pi;
            end
          end
          if (last_idx) state <= S_DEC;
          else idx <= idx + 1'b1;
        end
        S_DEC: begin
          nfill      <= '0;
          final_pass <= 1'b1;
          r_status   <= lob_pkg::ST_OK;
          if (r_cmd == lob_pkg::CMD_CANCEL) begin
            if (!found_v) r_status <= lob_pkg::ST_UNKNOWN;
            else used[found_i] <= 1'b0;
          end else if (r_qty == '0) begin
            r_status <= lob_pkg::ST_ZERO;
          end else if (found_v) begin
            r_status <= lob_pkg::ST_DUP;
          end else if (!free_v) begin
            r_status <= lob_pkg::ST_FULL;
          end else begin
            used[free_i] <= 1'b1;
            arr_cnt      <= arr_cnt + 1'b1;
            final_pass   <= 1'b0;
          end
          idx   <= '0;
          b_v   <= 1'b0;
          a_v   <= 1'b0;
          state <= S_SCAN2;
        end
        // best bid and best ask, one slot a cycle
        S_SCAN2: begin
          if (bid_better) begin
            b_v <= 1'b1; b_i <= pi; b_ent <= rd_data; b_age <= s_age;
          end
          if (ask_better) begin
            a_v <= 1'b1; a_i <= pi; a_ent <= rd_data; a_age <= s_age;
          end
          if (last_idx) state <= S_MATCH;
          else idx <= idx + 1'b1;
        end
        S_MATCH: begin
          if (!final_pass && nfill != 6'(lob_pkg::MAX_FILLS) && b_v && a_v &&
              b_ent.price >= a_ent.price) begin
            m_qty <= (b_ent.rem < a_ent.rem) ? b_ent.rem : a_ent.rem;
            state <= S_UPDB;
          end else begin
            final_pass <= 1'b1;
            state      <= S_EMIT;
          end
        end
        S_UPDB: begin
          if (b_ent.rem == m_qty) used[b_i] <= 1'b0;
          nfill <= nfill + 1'b1;
          state <= S_UPDA;
        end
        S_UPDA: begin
          if (a_ent.rem == m_qty) used[a_i] <= 1'b0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            if (final_pass) begin
              o_kind        <= lob_pkg::KIND_STAT;
              o_status      <= r_status;
              o_fill_price  <= '0;
              o_fill_qty    <= '0;
              o_buy_id      <= '0;
              o_sell_id     <= '0;
              o_best_bid    <= b_v ? b_ent.price : '0;
              o_bid_present <= b_v;
              o_best_ask    <= a_v ? a_ent.price : '0;
              o_ask_present <= a_v;
              o_last        <= 1'b1;
              state         <= S_IDLE;
            end else begin
              o_kind        <= lob_pkg::KIND_FILL;
              o_status      <= lob_pkg::ST_OK;
              o_fill_price  <= a_ent.price;
              o_fill_qty    <= m_qty;
              o_buy_id      <= b_ent.id;
              o_sell_id     <= a_ent.id;
              o_best_bid    <= '0;
              o_bid_present <= 1'b0;
              o_best_ask    <= '0;
              o_ask_present <= 1'b0;
              o_last        <= 1'b0;
              idx   <= '0;
              b_v   <= 1'b0;
              a_v   <= 1'b0;
              state <= S_SCAN2;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    nfill <= 6'(lob_pkg::MAX_FILLS)) else $error("fill count overrun");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (o_kind == o_last)) else $error("last mismatch");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
endmodule

// ----- design/limit_order_book_matcher.sv -----
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority limit order book with fill and status records.
// ----------------------------------------------------------------------------
// Usage: send one request item (add or cancel) on in_valid/in_ready. The block
// answers with zero or more fill items followed by one status item (last=1)
// on out_valid/out_ready.
// A two-entry queue takes requests while the engine works on an earlier one.
// Processing: the id/free-slot lookup walks all ORDER_SLOTS slots, one a cycle
// with a registered slot read, then each best-bid/best-ask search walks them
// again, once after the lookup and once more after each fill. The engine takes
// a new request only after it has sent the status item for the one before, so
// the serial slot walk sets the rate.
// Reset clears the book and the arrival counter at once; no clearing pass.
// When the receiver stalls, the output register holds its item and the
// engine waits, while the queue keeps taking up to two requests.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
  parameter int PRICE_BITS  = lob_pkg::PRICE_BITS_DEF,
  parameter int ID_BITS     = lob_pkg::ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [ID_BITS-1:0]    order_id,
  input  logic                  side,
  input  logic [PRICE_BITS-1:0] limit_price,
  input  logic [lob_pkg::QTY_BITS-1:0] quantity,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [lob_pkg::STATUS_BITS-1:0] status,
  output logic [PRICE_BITS-1:0] fill_price,
  output logic [lob_pkg::QTY_BITS-1:0] fill_qty,
  output logic [ID_BITS-1:0]    buy_id,
  output logic [ID_BITS-1:0]    sell_id,
  output logic [PRICE_BITS-1:0] best_bid,
  output logic                  bid_present,
  output logic [PRICE_BITS-1:0] best_ask,
  output logic                  ask_present,
  output logic                  last
);
  localparam int QB = lob_pkg::QTY_BITS;
  localparam int W  = 2 + ID_BITS + PRICE_BITS + QB;

  logic         q_valid, q_ready;
  logic [W-1:0] q_data;

  // front: queue raw requests
  lob_front #(.W(W), .DEPTH(2)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data({cmd, order_id, side, limit_price, quantity}),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  // back: lookup, rest, match, report
  lob_engine #(.ORDER_SLOTS(ORDER_SLOTS), .PRICE_BITS(PRICE_BITS), .ID_BITS(ID_BITS))
  u_engine (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_data[W-1]),
    .q_id(q_data[W-2 -: ID_BITS]),
    .q_side(q_data[PRICE_BITS+QB]),
    .q_price(q_data[QB +: PRICE_BITS]),
    .q_qty(q_data[QB-1:0]),
    .out_valid(out_valid), .out_ready(out_ready),
    .o_kind(kind), .o_status(status), .o_fill_price(fill_price),
    .o_fill_qty(fill_qty), .o_buy_id(buy_id), .o_sell_id(sell_id),
    .o_best_bid(best_bid), .o_bid_present(bid_present),
    .o_best_ask(best_ask), .o_ask_present(ask_present), .o_last(last)
  );
endmodule
